### design/toc_pkg.sv
`default_nettype none

package toc_pkg;

    // Field widths fixed by the stream and register formats
    localparam int STEP_W = 20;     // phase_step, unsigned Q4.16 turns
    localparam int SPAN_W = 24;     // span_cycles, unsigned Q8.16 turns
    localparam int WAVE_W = 16;     // wave_value, signed Q1.15
    localparam int MAG_W  = 15;     // cosine magnitude 0..32767
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 24'h010000;   // one turn

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_PLAYBACK     = 2'd0,
        CFG_TRIG_RESETS_PHASE = 2'd1,
        CFG_SPAN_CYCLES       = 2'd2
    } t_cfg_index;

    // Configuration registers as seen by the phase logic
    typedef struct packed {
        logic              loop_playback;
        logic              trigger_resets_phase;
        logic [SPAN_W-1:0] span_cycles;
    } t_cfg;

    // Per-item control carried alongside the cosine lookup
    typedef struct packed {
        logic play_pre;     // playing when the cosine is taken
        logic play_now;     // play flag after this tick's update
        logic neg;          // cosine is negative in this quadrant
    } t_tick_info;

    // Q30 coefficients of the even Taylor series of cos(pi/2 * x)
    localparam logic [31:0] POLY_COEF [6] = '{
        32'd1324675879, 32'd272375560, 32'd22401991,
        32'd987048, 32'd27060, 32'd506
    };
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // cos(pi/2 * r / 2^qbits) in Q1.15 magnitude; evaluated at elaboration only
    function automatic logic [MAG_W-1:0] quarter_cos(input int r, input int qbits);
        logic [63:0] x;
        logic [63:0] u;
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] v;
        x = 64'(r) << (30 - qbits);
        if (x > Q30_ONE) begin
            x = Q30_ONE;
        end
        u = (x * x) >> 30;
        p = 64'(POLY_COEF[5]);
        for (int i = 4; i >= 0; i--) begin
            t = (p * u) >> 30;
            p = (t > 64'(POLY_COEF[i])) ? 64'd0 : 64'(POLY_COEF[i]) - t;
        end
        t = (p * u) >> 30;
        p = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
        v = (p * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/toc_cos_rom.sv
`default_nettype none

module toc_cos_rom #(
    parameter int COS_TABLE_BITS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rd_en,
    input  wire logic [COS_TABLE_BITS-2:0]   i_addr,
    output logic [toc_pkg::MAG_W-1:0]        o_data
);
    import toc_pkg::*;

    localparam int QB     = COS_TABLE_BITS - 2;
    localparam int QTR_N  = 2 ** QB;
    localparam int DEPTH  = 2 ** (QB + 1);

    logic [MAG_W-1:0] w_tab [DEPTH];
    logic [MAG_W-1:0] r_data;

    // Quarter-wave table, points 0..QTR_N inclusive; upper rows are never addressed
    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        if (g <= QTR_N) begin : g_used
            assign w_tab[g] = quarter_cos(g, QB);
        end else begin : g_spare
            assign w_tab[g] = '0;
        end
    end

    // Registered read, held while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### design/toc_phase_core.sv
`default_nettype none

module toc_phase_core #(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int COS_TABLE_BITS  = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic                          i_trigger,
    input  wire logic [toc_pkg::STEP_W-1:0]    i_phase_step,
    input  wire toc_pkg::t_cfg                 i_cfg,
    output toc_pkg::t_tick_info                o_info,
    output logic [COS_TABLE_BITS-2:0]          o_rom_addr
);
    import toc_pkg::*;

    localparam int PW  = PHASE_FRAC_BITS + 9;   // phase accumulator
    localparam int SPW = PHASE_FRAC_BITS + 8;   // span in phase format
    localparam int STW = PHASE_FRAC_BITS + 4;   // step in phase format
    localparam int CTB = COS_TABLE_BITS;
    localparam int QB  = COS_TABLE_BITS - 2;
    localparam int AW  = QB + 1;
    localparam logic [AW-1:0] QTR_N = AW'(2 ** QB);

    logic [PW-1:0]  r_phase;
    logic           r_play;
    logic [PW-1:0]  n_phase;
    logic           n_play;

    logic [STW-1:0] w_step_ph;
    logic [SPW-1:0] w_span_ph;
    logic [PW-1:0]  w_base;
    logic [PW-1:0]  w_sum;
    logic           w_wrap;
    logic           w_play_pre;
    logic [CTB-1:0] w_k;
    logic [1:0]     w_quad;
    logic [QB-1:0]  w_rem;

    // Bring Q.16 step and span into the phase format
    if (PHASE_FRAC_BITS >= 16) begin : g_up
        assign w_step_ph = STW'(i_phase_step) << (PHASE_FRAC_BITS - 16);
        assign w_span_ph = SPW'(i_cfg.span_cycles) << (PHASE_FRAC_BITS - 16);
    end else begin : g_down
        assign w_step_ph = STW'(i_phase_step >> (16 - PHASE_FRAC_BITS));
        assign w_span_ph = SPW'(i_cfg.span_cycles >> (16 - PHASE_FRAC_BITS));
    end

    // Trigger starts playback and may zero the phase before the lookup
    assign w_play_pre = r_play | i_trigger;
    assign w_base     = (i_trigger && i_cfg.trigger_resets_phase) ? '0 : r_phase;

    // Table index from the phase fraction
    if (PHASE_FRAC_BITS >= CTB) begin : g_idx_trunc
        assign w_k = w_base[PHASE_FRAC_BITS-1 -: CTB];
    end else begin : g_idx_pad
        assign w_k = CTB'(w_base[PHASE_FRAC_BITS-1:0]) << (CTB - PHASE_FRAC_BITS);
    end
    assign w_quad = w_k[CTB-1:CTB-2];
    assign w_rem  = w_k[QB-1:0];

    // Fold into the first quadrant: odd quadrants read the mirrored point
    assign o_rom_addr    = w_quad[0] ? (QTR_N - AW'(w_rem)) : AW'(w_rem);
    assign o_info.neg    = w_quad[1] ^ w_quad[0];
    assign o_info.play_pre = w_play_pre;
    assign o_info.play_now = n_play;

    // Advance phase, subtract one span on overflow, end one-shot playback unless retriggered
    assign w_sum  = w_base + PW'(w_step_ph);
    assign w_wrap = w_sum > PW'(w_span_ph);

    always_comb begin
        n_phase = w_wrap ? (w_sum - PW'(w_span_ph)) : w_sum;
        n_play  = w_play_pre;
        if (w_wrap && w_play_pre && !i_cfg.loop_playback) begin
            if (i_trigger) begin
                if (i_cfg.trigger_resets_phase) begin
                    n_phase = '0;
                end
            end else begin
                n_play = 1'b0;
            end
        end
    end

    // Hold state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_play  <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_play  <= n_play;
        end
    end

    a_trig_plays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_trigger) |=> r_play)
        else $error("trigger did not leave playback running");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !r_play && !i_trigger) |=> !r_play)
        else $error("playback started without a trigger");

    a_recycle_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_play && i_cfg.loop_playback) |=> r_play)
        else $error("looping playback stopped");

endmodule

`default_nettype wire

### design/triggered_cosine_oscillator.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: phase_step; tuser: trigger
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: wave_value; tuser: playing
// cfg       in   i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_wdata
//
// One sample per cycle sustained while the output is not stalled.
// Depth is input register, phase update with registered table read, result register.
// Reset zeroes the phase, stops playback, clears the held wave and loads register defaults.
// A stalled output keeps its result; s_axis_tready stays high while any stage is free.
`default_nettype none

module triggered_cosine_oscillator #(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int COS_TABLE_BITS  = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // stream in
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,   // [19:0] phase_step
    input  wire logic                              s_axis_tuser,   // [0] trigger
    // stream out
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [toc_pkg::WAVE_W-1:0]             m_axis_tdata,   // [15:0] wave_value
    output logic                                   m_axis_tuser,   // [0] playing
    // configuration
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [toc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [toc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import toc_pkg::*;

    localparam int AW = COS_TABLE_BITS - 1;

    t_cfg              r_cfg;
    logic              r_s1_valid;
    logic              r_s1_trig;
    logic [STEP_W-1:0] r_s1_step;
    logic              r_s2_valid;
    t_tick_info        r_s2_info;
    logic              r_out_valid;
    logic [WAVE_W-1:0] r_wave;
    logic              r_playing;

    logic              n_s1_valid;
    logic              n_s2_valid;
    logic              n_out_valid;
    logic [WAVE_W-1:0] n_wave;

    logic              w_acc;
    logic              w_rdy_out;
    logic              w_rdy2;
    logic              w_mv1;
    logic              w_mv2;
    t_tick_info        w_info;
    logic [AW-1:0]     w_rom_addr;
    logic [MAG_W-1:0]  w_mag;

    // Stage moves; each stage takes a new item when empty or emptying
    assign w_rdy_out     = !r_out_valid || m_axis_tready;
    assign w_rdy2        = !r_s2_valid || w_rdy_out;
    assign s_axis_tready = !r_s1_valid || w_rdy2;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_mv1         = r_s1_valid && w_rdy2;
    assign w_mv2         = r_s2_valid && w_rdy_out;

    always_comb begin
        n_s1_valid  = w_acc ? 1'b1 : (w_mv1 ? 1'b0 : r_s1_valid);
        n_s2_valid  = w_mv1 ? 1'b1 : (w_mv2 ? 1'b0 : r_s2_valid);
        n_out_valid = w_mv2 ? 1'b1 : ((r_out_valid && m_axis_tready) ? 1'b0 : r_out_valid);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_playback        <= 1'b0;
            r_cfg.trigger_resets_phase <= 1'b0;
            r_cfg.span_cycles          <= SPAN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOOP_PLAYBACK:     r_cfg.loop_playback <= i_cfg_wdata[0];
                CFG_TRIG_RESETS_PHASE: r_cfg.trigger_resets_phase <= i_cfg_wdata[0];
                CFG_SPAN_CYCLES:       r_cfg.span_cycles <= i_cfg_wdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_trig <= s_axis_tuser;
            r_s1_step <= s_axis_tdata[STEP_W-1:0];
        end
    end

    toc_phase_core #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .COS_TABLE_BITS  (COS_TABLE_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_mv1),
        .i_trigger    (r_s1_trig),
        .i_phase_step (r_s1_step),
        .i_cfg        (r_cfg),
        .o_info       (w_info),
        .o_rom_addr   (w_rom_addr)
    );

    toc_cos_rom #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (w_mv1),
        .i_addr  (w_rom_addr),
        .o_data  (w_mag)
    );

    // Lookup stage control, aligned with the table read register
    always_ff @(posedge i_clk) begin
        if (w_mv1) begin
            r_s2_info <= w_info;
        end
    end

    // Apply sign while playing, otherwise hold the last wave value
    always_comb begin
        n_wave = r_wave;
        if (r_s2_info.play_pre) begin
            n_wave = r_s2_info.neg ? (WAVE_W'(0) - WAVE_W'(w_mag)) : WAVE_W'(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else if (w_mv2) begin
            r_wave <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv2) begin
            r_playing <= r_s2_info.play_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_wave;
    assign m_axis_tuser  = r_playing;

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input blocked while the result register is free");

    a_hold_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv2 && !r_s2_info.play_pre) |=> $stable(r_wave))
        else $error("wave value changed while stopped");

    a_play_implies_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_info.play_now) |-> r_s2_info.play_pre)
        else $error("playing flag set on a tick that took no cosine");

endmodule

`default_nettype wire
